// ===== rtl/lfx_pkg.sv =====
// Package for the link frame transmitter: framing constants, the job record
// passed from the front end to the back end, and the stuffing test.
// No dependencies.
package lfx_pkg;

   localparam logic [7:0] LFX_FLAG       = 8'h7e;
   localparam logic [7:0] LFX_ESC        = 8'h7d;
   localparam logic [7:0] LFX_ESC_XOR    = 8'h20;
   localparam logic [7:0] LFX_CTRL_SET   = 8'h03;
   localparam logic [7:0] LFX_CTRL_I0    = 8'h00;
   localparam logic [7:0] LFX_CTRL_I1    = 8'h40;
   localparam logic [7:0] LFX_ADDR_RESET = 8'h03;

   localparam logic LFX_MODE_DATA  = 1'b0;
   localparam logic LFX_MODE_SUPER = 1'b1;

   localparam int LFX_QUEUE_DEPTH = 2;

   // One classified request, ready for the back end to serialise
   typedef struct packed {
      logic       sup;   // supervisory frame
      logic       hdr;   // emit FLAG, address, control, BCC1 first
      logic [7:0] addr;
      logic [7:0] ctrl;
      logic [7:0] data;  // payload byte (data frames)
      logic       last;  // close the frame with BCC2 and FLAG
      logic [7:0] bcc;   // BCC2 of the whole frame, valid with last
   } lfx_job_type;

   // A byte that must be escaped on the line
   function automatic logic lfx_is_special(input logic [7:0] b);
      return (b == LFX_FLAG) || (b == LFX_ESC);
   endfunction

endpackage

// ===== rtl/lfx_req_if.sv =====
// Request channel interface of the link frame transmitter.
// No dependencies.
interface lfx_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output mode, output data_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input mode, input data_byte, input last_byte,
                   output ready);
endinterface

// ===== rtl/lfx_rsp_if.sv =====
// Response channel interface of the link frame transmitter.
// No dependencies.
interface lfx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       burst_last;
   logic       frame_end;

   modport source (output valid, output tx_byte, output burst_last, output frame_end,
                   input ready);
   modport sink   (input valid, input tx_byte, input burst_last, input frame_end,
                   output ready);
endinterface

// ===== rtl/lfx_csr_if.sv =====
// Register write interface of the link frame transmitter.
// No dependencies.
interface lfx_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lfx_front.sv =====
// Front end: accepts requests, tracks frame state and classifies each
// request into a job. Depends on lfx_pkg, lfx_req_if and lfx_csr_if.
module lfx_front (
   input  logic                clock,
   input  logic                reset,
   lfx_req_if.sink             req_chan,
   lfx_csr_if.sink             csr_chan,
   output logic                job_valid,
   output lfx_pkg::lfx_job_type job,
   input  logic                job_ready
);
   import lfx_pkg::*;

   logic       in_frame_ff, in_frame_in;
   logic       seq_bit_ff, seq_bit_in;
   logic [7:0] parity_ff, parity_in;
   logic [7:0] address_ff, address_in;
   logic       accept;
   logic [7:0] par_new;
   logic [7:0] ctrl_data;

   assign req_chan.ready = job_ready;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && job_ready;
   assign job_valid      = req_chan.valid;

   assign ctrl_data = seq_bit_ff ? LFX_CTRL_I1 : LFX_CTRL_I0;
   assign par_new   = (in_frame_ff ? parity_ff : 8'h00) ^ req_chan.data_byte;

   always_comb begin
      job.addr = address_ff;
      job.data = req_chan.data_byte;
      job.bcc  = par_new;
      if (req_chan.mode == LFX_MODE_SUPER) begin
         job.sup  = 1'b1;
         job.hdr  = 1'b1;
         job.ctrl = req_chan.data_byte;
         job.last = 1'b0;
      end else begin
         job.sup  = 1'b0;
         job.hdr  = !in_frame_ff;
         job.ctrl = ctrl_data;
         job.last = req_chan.last_byte;
      end
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      seq_bit_in  = seq_bit_ff;
      parity_in   = parity_ff;
      address_in  = csr_chan.valid ? csr_chan.data : address_ff;
      if (accept) begin
         if (req_chan.mode == LFX_MODE_SUPER) begin
            // abandon any open frame
            in_frame_in = 1'b0;
            parity_in   = 8'h00;
            if (req_chan.data_byte == LFX_CTRL_SET) begin
               seq_bit_in = 1'b0;
            end
         end else if (req_chan.last_byte) begin
            in_frame_in = 1'b0;
            parity_in   = 8'h00;
            seq_bit_in  = !seq_bit_ff;
         end else begin
            in_frame_in = 1'b1;
            parity_in   = par_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         seq_bit_ff  <= 1'b0;
         parity_ff   <= 8'h00;
         address_ff  <= LFX_ADDR_RESET;
      end else begin
         in_frame_ff <= in_frame_in;
         seq_bit_ff  <= seq_bit_in;
         parity_ff   <= parity_in;
         address_ff  <= address_in;
      end
   end

endmodule

// ===== rtl/lfx_queue.sv =====
// Short job queue between front and back end.
// Depends on lfx_pkg.
module lfx_queue #(
   parameter int DEPTH = lfx_pkg::LFX_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  lfx_pkg::lfx_job_type push_job,
   output logic                pop_valid,
   input  logic                pop_ready,
   output lfx_pkg::lfx_job_type pop_job
);
   import lfx_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lfx_job_type      mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/lfx_back.sv =====
// Back end: steps through the bytes of each job, escaping payload and BCC2,
// into a registered response stage. Depends on lfx_pkg and lfx_rsp_if.
module lfx_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  lfx_pkg::lfx_job_type job,
   lfx_rsp_if.source           rsp_chan
);
   import lfx_pkg::*;

   localparam logic [3:0] ST_OPEN  = 4'd0;
   localparam logic [3:0] ST_ADDR  = 4'd1;
   localparam logic [3:0] ST_CTRL  = 4'd2;
   localparam logic [3:0] ST_BCC1  = 4'd3;
   localparam logic [3:0] ST_DESC  = 4'd4;
   localparam logic [3:0] ST_DATA  = 4'd5;
   localparam logic [3:0] ST_PESC  = 4'd6;
   localparam logic [3:0] ST_PAR   = 4'd7;
   localparam logic [3:0] ST_CLOSE = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   lfx_job_type job_ff, job_in;
   logic        busy_ff, busy_in;
   logic [3:0]  step_ff, step_in, step_next, step_first;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  tx_ff;
   logic        burst_last_ff, frame_end_ff;
   logic        out_free, emit, done, pop;
   logic        data_esc, par_esc, new_data_esc;
   logic [7:0]  byte_out;

   assign data_esc     = lfx_is_special(job_ff.data);
   assign par_esc      = lfx_is_special(job_ff.bcc);
   assign new_data_esc = lfx_is_special(job.data);

   // first step of the job about to be loaded
   always_comb begin
      if (job.hdr) begin
         step_first = ST_OPEN;
      end else if (new_data_esc) begin
         step_first = ST_DESC;
      end else begin
         step_first = ST_DATA;
      end
   end

   always_comb begin
      unique case (step_ff)
         ST_OPEN:  step_next = ST_ADDR;
         ST_ADDR:  step_next = ST_CTRL;
         ST_CTRL:  step_next = ST_BCC1;
         ST_BCC1:  step_next = job_ff.sup ? ST_CLOSE : (data_esc ? ST_DESC : ST_DATA);
         ST_DESC:  step_next = ST_DATA;
         ST_DATA:  step_next = job_ff.last ? (par_esc ? ST_PESC : ST_PAR) : ST_DONE;
         ST_PESC:  step_next = ST_PAR;
         ST_PAR:   step_next = ST_CLOSE;
         default:  step_next = ST_DONE;
      endcase
   end

   always_comb begin
      unique case (step_ff)
         ST_ADDR:          byte_out = job_ff.addr;
         ST_CTRL:          byte_out = job_ff.ctrl;
         ST_BCC1:          byte_out = job_ff.addr ^ job_ff.ctrl;
         ST_DESC, ST_PESC: byte_out = LFX_ESC;
         ST_DATA:          byte_out = job_ff.data ^ (data_esc ? LFX_ESC_XOR : 8'h00);
         ST_PAR:           byte_out = job_ff.bcc ^ (par_esc ? LFX_ESC_XOR : 8'h00);
         default:          byte_out = LFX_FLAG;
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign emit      = busy_ff && out_free;
   assign done      = (step_next == ST_DONE);
   assign pop       = job_valid && (!busy_ff || (emit && done));
   assign job_ready = !busy_ff || (emit && done);

   always_comb begin
      job_in  = pop ? job : job_ff;
      step_in = pop ? step_first : (emit ? step_next : step_ff);
      if (pop) begin
         busy_in = 1'b1;
      end else if (emit && done) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= ST_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         tx_ff         <= byte_out;
         burst_last_ff <= done;
         frame_end_ff  <= (step_ff == ST_CLOSE);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.tx_byte    = tx_ff;
   assign rsp_chan.burst_last = burst_last_ff;
   assign rsp_chan.frame_end  = frame_end_ff;

endmodule

// ===== rtl/link_frame_transmitter.sv =====
// Link frame transmitter top level: front end, job queue and back end.
// Depends on lfx_pkg, the three channel interfaces and the lfx_* modules.
//
// Usage:
//   req_chan  - one request per handshake: mode 0 is a payload byte of a
//               data frame (last_byte closes it), mode 1 sends a supervisory
//               frame with data_byte as control code (SET clears the
//               sequence bit; an open data frame is abandoned).
//   rsp_chan  - one line byte per handshake, with burst_last on the final
//               byte a request causes and frame_end on each closing FLAG.
//   csr_chan  - writes the address byte; always ready, write only when idle.
// The first byte of an accepted request passes through the queue, the back
//   end's job register and the response register before it is offered.
// Throughput: one line byte per cycle from the back end's byte sequencer
//   while rsp_chan is ready, so a request yields 1 to 9 line bytes (a plain
//   payload byte 1, an escaped one 2, a supervisory frame 5).
// Requests are taken while the queue has room, independent of the back end.
// When the receiver stalls, hold the response register and let the queue
//   fill; then drop req_chan.ready until a slot frees.
// Reset (synchronous): close any frame, clear sequence bit and BCC2,
//   empty the queue and restore the address byte to 0x03.
module link_frame_transmitter #(
   parameter int QUEUE_DEPTH = lfx_pkg::LFX_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   lfx_req_if.sink    req_chan,
   lfx_rsp_if.source  rsp_chan,
   lfx_csr_if.sink    csr_chan
);
   import lfx_pkg::*;

   // front end to queue
   logic        fq_valid, fq_ready;
   lfx_job_type fq_job;
   // queue to back end
   logic        qb_valid, qb_ready;
   lfx_job_type qb_job;

   // Classify requests and keep the frame state
   lfx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .job_valid (fq_valid),
      .job       (fq_job),
      .job_ready (fq_ready)
   );

   // Decouple request acceptance from byte output
   lfx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_job   (fq_job),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_job    (qb_job)
   );

   // Serialise each job, one line byte per cycle while the receiver is ready
   lfx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job       (qb_job),
      .rsp_chan  (rsp_chan)
   );

endmodule
